// File: hdl/tsjf_pkg.sv
`default_nettype none

package tsjf_pkg;

   localparam int COORD_BITS = 16;
   localparam int MOVE_BITS  = COORD_BITS + 1;
   localparam int CFG_BITS   = 16;
   localparam int CMP_BITS   = (MOVE_BITS > CFG_BITS) ? MOVE_BITS : CFG_BITS;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = CFG_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESSURE_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_JITTER_LIMIT       = 1'd1;

   localparam logic [CFG_BITS-1:0] PRESSURE_THRESHOLD_RESET = 16'd1;
   localparam logic [CFG_BITS-1:0] JITTER_LIMIT_RESET       = 16'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [MOVE_BITS-1:0]  move_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      is_pressed;
   } point_type;

   typedef struct packed {
      coord_type        x;
      coord_type        y;
      logic [CFG_BITS-1:0] pressure;
      logic             batch_end;
   } sample_type;

   typedef struct packed {
      coord_type pos;
      move_type  move;
   } axis_type;

endpackage

`default_nettype wire

// File: hdl/touch_sample_jitter_filter_core.sv
// Flow: a request transfer loads the input register; the filter logic then writes
// its result into the result register, which drives the outputs.
// Throughput: one sample per cycle; a stalled result holds back the input
// register only, and new samples wait while it is held.
// Reset: synchronous, active high; clears the reported point, pressed flag and
// last moves, empties both registers and restores threshold 1 and jitter limit 3.
`default_nettype none

module touch_sample_jitter_filter_core
   import tsjf_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,

   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  [COORD_BITS-1:0]     req_sample_x,
   input  wire  [COORD_BITS-1:0]     req_sample_y,
   input  wire  [CFG_BITS-1:0]       req_pressure,
   input  wire                       req_batch_end,

   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic [COORD_BITS-1:0]     rsp_point_x,
   output logic [COORD_BITS-1:0]     rsp_point_y,
   output logic                      rsp_is_pressed,

   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire  [CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [CSR_DATA_BITS-1:0]  csr_data
);

   logic [CFG_BITS-1:0] threshold_ff;
   logic [CFG_BITS-1:0] jitter_ff;

   logic       in_valid_ff, in_valid_in;
   sample_type in_ff, in_in;

   logic       out_valid_ff, out_valid_in;
   point_type  out_ff, out_in;

   coord_type  rep_x_ff, rep_x_in;
   coord_type  rep_y_ff, rep_y_in;
   logic       rep_pressed_ff, rep_pressed_in;
   move_type   move_x_ff, move_x_in;
   move_type   move_y_ff, move_y_in;

   logic       advance;
   logic       pressed;
   logic       handle;
   logic       emit;
   axis_type   fx, fy;

   // Cancel a reversed move on one axis whose magnitude is below the jitter limit.
   function automatic axis_type filter_axis(coord_type pos, coord_type prev,
                                            move_type last_move,
                                            logic [CFG_BITS-1:0] limit);
      axis_type             r;
      move_type             d;
      logic [MOVE_BITS-1:0] m;
      logic                 opposite;
      d = MOVE_BITS'(pos) - MOVE_BITS'(prev);
      m = d[MOVE_BITS-1] ? MOVE_BITS'(-d) : MOVE_BITS'(d);
      opposite = (d[MOVE_BITS-1] && !last_move[MOVE_BITS-1] && (last_move != '0))
              || (!d[MOVE_BITS-1] && (d != '0) && last_move[MOVE_BITS-1]);
      if (opposite && (CMP_BITS'(m) < CMP_BITS'(limit))) begin
         r.pos  = prev;
         r.move = '0;
      end else begin
         r.pos  = pos;
         r.move = d;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= PRESSURE_THRESHOLD_RESET;
         jitter_ff    <= JITTER_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PRESSURE_THRESHOLD: threshold_ff <= csr_data;
            CSR_JITTER_LIMIT:       jitter_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // The result register frees up when empty or when its transfer completes.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_in.x         = coord_type'(req_sample_x);
         in_in.y         = coord_type'(req_sample_y);
         in_in.pressure  = req_pressure;
         in_in.batch_end = req_batch_end;
      end
   end

   always_comb begin
      pressed = in_ff.pressure >= threshold_ff;
      handle  = (pressed != rep_pressed_ff) || in_ff.batch_end;
      fx      = filter_axis(in_ff.x, rep_x_ff, move_x_ff, jitter_ff);
      fy      = filter_axis(in_ff.y, rep_y_ff, move_y_ff, jitter_ff);
      emit    = advance && handle
             && ((pressed != rep_pressed_ff) || (fx.move != '0) || (fy.move != '0));

      rep_x_in       = rep_x_ff;
      rep_y_in       = rep_y_ff;
      rep_pressed_in = rep_pressed_ff;
      move_x_in      = move_x_ff;
      move_y_in      = move_y_ff;
      if (emit) begin
         rep_x_in       = fx.pos;
         rep_y_in       = fy.pos;
         rep_pressed_in = pressed;
         if (fx.move != '0) begin
            move_x_in = fx.move;
         end
         if (fy.move != '0) begin
            move_y_in = fy.move;
         end
      end

      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = emit;
         out_in.x          = fx.pos;
         out_in.y          = fy.pos;
         out_in.is_pressed = pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         rep_x_ff       <= '0;
         rep_y_ff       <= '0;
         rep_pressed_ff <= 1'b0;
         move_x_ff      <= '0;
         move_y_ff      <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         rep_x_ff       <= rep_x_in;
         rep_y_ff       <= rep_y_in;
         rep_pressed_ff <= rep_pressed_in;
         move_x_ff      <= move_x_in;
         move_y_ff      <= move_y_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_point_x    = out_ff.x;
   assign rsp_point_y    = out_ff.y;
   assign rsp_is_pressed = out_ff.is_pressed;

endmodule

`default_nettype wire

// File: hdl/tsjf_checker.sv
`default_nettype none

module tsjf_checker
   import tsjf_pkg::*;
(
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_stall,
   input wire                       rsp_valid,
   input wire                       rsp_stall,
   input wire  [COORD_BITS-1:0]     rsp_point_x,
   input wire  [COORD_BITS-1:0]     rsp_point_y,
   input wire                       rsp_is_pressed
);

   // A stalled result stays in place with its payload unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x)
         && $stable(rsp_point_y) && $stable(rsp_is_pressed))
      else $error("stalled result changed");

   // Reset leaves no result showing.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A new result follows a request transfer, through the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching request");

   // With an empty result register the input side never stalls.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while result register empty");

endmodule

bind touch_sample_jitter_filter_core tsjf_checker u_tsjf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_point_x    (rsp_point_x),
   .rsp_point_y    (rsp_point_y),
   .rsp_is_pressed (rsp_is_pressed)
);

`default_nettype wire

// File: tb/sv/touch_sample_jitter_filter_core_test.sv
`timescale 1ns / 1ps

module touch_sample_jitter_filter_core_test;
   import tsjf_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;
   localparam int COORD_MAX      = 32767;
   localparam int COORD_MIN      = -32768;
   localparam int FIELD_MAX      = 65535;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_BURSTY} stall_mode_type;

   // Mirrors the filter: tracks the last reported point and moves, and keeps the
   // points that the block still owes in arrival order.
   class point_scoreboard;
      logic [CFG_BITS-1:0] threshold;
      logic [CFG_BITS-1:0] jitter;
      coord_type           rep_x;
      coord_type           rep_y;
      logic                rep_pressed;
      move_type            move_x;
      move_type            move_y;
      point_type           expected_points[$];
      int                  errors;
      int                  checked;

      function new();
         threshold   = PRESSURE_THRESHOLD_RESET;
         jitter      = JITTER_LIMIT_RESET;
         rep_x       = '0;
         rep_y       = '0;
         rep_pressed = 1'b0;
         move_x      = '0;
         move_y      = '0;
         errors      = 0;
         checked     = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_PRESSURE_THRESHOLD: threshold = val;
            CSR_JITTER_LIMIT:       jitter = val;
            default: ;
         endcase
      endfunction

      // Move on one axis after a small reversal has been cancelled.
      function move_type filtered_move(coord_type pos, coord_type prev, move_type last);
         move_type d;
         int       magnitude;
         bit       reversed;
         d = pos - prev;
         magnitude = (d < 0) ? -int'(d) : int'(d);
         reversed = (d < 0 && last > 0) || (d > 0 && last < 0);
         if (reversed && magnitude < int'(jitter))
            return '0;
         return d;
      endfunction

      function void note_sample(sample_type s);
         logic      pressed;
         move_type  dx;
         move_type  dy;
         point_type p;
         pressed = (s.pressure >= threshold);
         // A sample with an unchanged pressed state and no batch end produces no point.
         if (pressed == rep_pressed && !s.batch_end)
            return;
         dx = filtered_move(s.x, rep_x, move_x);
         dy = filtered_move(s.y, rep_y, move_y);
         if (pressed == rep_pressed && dx == 0 && dy == 0)
            return;
         p.x = (dx == 0) ? rep_x : s.x;
         p.y = (dy == 0) ? rep_y : s.y;
         p.is_pressed = pressed;
         rep_x = p.x;
         rep_y = p.y;
         rep_pressed = pressed;
         if (dx != 0)
            move_x = dx;
         if (dy != 0)
            move_y = dy;
         expected_points.push_back(p);
      endfunction

      task report(string msg);
         if (errors < 50)
            $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_point(coord_type x, coord_type y, logic pressed);
         point_type want;
         if (expected_points.size() == 0) begin
            report($sformatf("unexpected point (%0d, %0d) pressed %0b", x, y, pressed));
            return;
         end
         want = expected_points.pop_front();
         checked++;
         if (x !== want.x)
            report($sformatf("point_x %0d, expected %0d", x, want.x));
         if (y !== want.y)
            report($sformatf("point_y %0d, expected %0d", y, want.y));
         if (pressed !== want.is_pressed)
            report($sformatf("is_pressed %0b, expected %0b", pressed, want.is_pressed));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [COORD_BITS-1:0]     req_sample_x = '0;
   logic [COORD_BITS-1:0]     req_sample_y = '0;
   logic [CFG_BITS-1:0]       req_pressure = '0;
   logic                      req_batch_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [COORD_BITS-1:0]     rsp_point_x;
   logic [COORD_BITS-1:0]     rsp_point_y;
   logic                      rsp_is_pressed;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   point_scoreboard sb;
   bit              hold_request = 1'b0;
   bit              gaps_on = 1'b1;
   int              burst_left = 0;
   int              samples_sent = 0;
   int              settings_done = 0;
   int              cur_thr = PRESSURE_THRESHOLD_RESET;
   int              cur_jit = JITTER_LIMIT_RESET;
   int              idle_cycles = 0;

   touch_sample_jitter_filter_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .req_pressure   (req_pressure),
      .req_batch_end  (req_batch_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_is_pressed (rsp_is_pressed),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin : monitor
      sample_type seen;
      if (!reset && sb != null) begin
         if (csr_valid && csr_ready)
            sb.set_reg(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            seen.x = req_sample_x;
            seen.y = req_sample_y;
            seen.pressure = req_pressure;
            seen.batch_end = req_batch_end;
            sb.note_sample(seen);
         end
         if (rsp_valid && !rsp_stall)
            sb.check_point(rsp_point_x, rsp_point_y, rsp_is_pressed);
      end
   end

   // Result side back-pressure: short stretches of different stall patterns, and
   // one long hold-off when the stimulus asks for it.
   initial begin : result_stall
      stall_mode_type mode;
      int             stretch_left;
      int             hold_left;
      int             tick;
      bit             stall_now;
      mode = STALL_NONE;
      stretch_left = 0;
      hold_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
         end else if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (stretch_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            stretch_left = $urandom_range(16, 96);
         end
         stretch_left--;
         tick++;
         case (mode)
            STALL_NONE:   stall_now = 1'b0;
            STALL_RANDOM: stall_now = ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  stall_now = (tick % 4 != 0);
            default:      stall_now = (tick % 7 < 2);
         endcase
         rsp_stall <= (hold_left != 0) || stall_now;
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   function automatic int clamp_coord(int v);
      if (v > COORD_MAX)
         return COORD_MAX;
      if (v < COORD_MIN)
         return COORD_MIN;
      return v;
   endfunction

   function automatic int pick_pressure(bit pressed);
      if (pressed) begin
         if ($urandom_range(0, 3) == 0)
            return cur_thr;
         return $urandom_range(cur_thr, FIELD_MAX);
      end
      if (cur_thr == 0)
         return $urandom_range(0, FIELD_MAX);
      if ($urandom_range(0, 3) == 0)
         return cur_thr - 1;
      return $urandom_range(0, cur_thr - 1);
   endfunction

   task automatic send_sample(input int x, input int y, input int p, input bit be);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample_x <= x[COORD_BITS-1:0];
      req_sample_y <= y[COORD_BITS-1:0];
      req_pressure <= p[CFG_BITS-1:0];
      req_batch_end <= be;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   // Holds the input off until every expected point has arrived, then lets the
   // pipeline empty of samples that produce nothing.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_points.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input int thr, input int jit);
      csr_valid <= 1'b1;
      csr_index <= CSR_PRESSURE_THRESHOLD;
      csr_data <= thr[CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_JITTER_LIMIT;
      csr_data <= jit[CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_thr = thr;
      cur_jit = jit;
      settings_done++;
   endtask

   task automatic run_stroke();
      int x, y, n, span, step;
      case ($urandom_range(0, 3))
         0: span = 2;
         1: span = (cur_jit < 64) ? cur_jit + 1 : 64;
         2: span = 400;
         default: span = 40000;
      endcase
      if ($urandom_range(0, 3) == 0) begin
         x = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 20)
                                  : COORD_MIN + $urandom_range(0, 20);
         y = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 20)
                                  : COORD_MIN + $urandom_range(0, 20);
      end else begin
         x = $urandom_range(0, FIELD_MAX);
         x -= 32768;
         y = $urandom_range(0, FIELD_MAX);
         y -= 32768;
      end
      send_sample(x, y, pick_pressure(1'b1), 1'($urandom_range(0, 1)));
      n = $urandom_range(2, 14);
      for (int i = 0; i < n; i++) begin
         step = $urandom_range(0, 2 * span);
         x = clamp_coord(x + step - span);
         step = $urandom_range(0, 2 * span);
         y = clamp_coord(y + step - span);
         // Now and then a release glitch in the middle of a stroke.
         send_sample(x, y, pick_pressure($urandom_range(0, 9) != 0), $urandom_range(0, 2) == 0);
      end
      send_sample(x, y, pick_pressure(1'b0), 1'($urandom_range(0, 1)));
   endtask

   task automatic run_phase(input int count);
      int target;
      target = samples_sent + count;
      while (samples_sent < target) begin
         if ($urandom_range(0, 4) != 0) begin
            run_stroke();
         end else begin
            repeat ($urandom_range(1, 3))
               send_sample(int'($urandom_range(0, FIELD_MAX)) - 32768,
                           int'($urandom_range(0, FIELD_MAX)) - 32768,
                           $urandom_range(0, FIELD_MAX), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin : stimulus
      int thr, jit;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed samples under the reset settings.
      send_sample(100, 200, 500, 1'b0);
      send_sample(105, 205, 500, 1'b0);
      send_sample(110, 190, 500, 1'b0);
      send_sample(112, 198, 500, 1'b1);
      send_sample(112, 199, 500, 1'b1);
      send_sample(COORD_MAX, COORD_MIN, FIELD_MAX, 1'b1);
      send_sample(COORD_MIN, COORD_MAX, FIELD_MAX, 1'b1);
      send_sample(0, 0, 0, 1'b1);
      send_sample(5, 5, 0, 1'b0);
      send_sample(-1, -1, 1, 1'b1);
      send_sample(-3, 1, 1, 1'b1);
      send_sample(-2, 0, 2, 1'b1);
      send_sample(-2, 0, 2, 1'b1);
      send_sample(40, -40, 0, 1'b1);

      // Zero threshold and zero jitter limit.
      wait_idle();
      write_regs(0, 0);
      send_sample(41, -41, 0, 1'b1);
      send_sample(40, -40, 0, 1'b1);
      send_sample(39, -39, 0, 1'b0);

      // Both settings at their maximum.
      wait_idle();
      write_regs(FIELD_MAX, FIELD_MAX);
      send_sample(COORD_MAX, COORD_MAX, FIELD_MAX - 1, 1'b0);
      send_sample(COORD_MAX, COORD_MAX, FIELD_MAX, 1'b0);
      send_sample(-COORD_MAX, 0, FIELD_MAX, 1'b1);
      send_sample(COORD_MIN, COORD_MIN, FIELD_MAX, 1'b1);
      send_sample(COORD_MAX, 0, FIELD_MAX, 1'b1);

      // Alternate press and release with no gaps while the result side holds
      // off, so that the block backs up into its input.
      wait_idle();
      write_regs(PRESSURE_THRESHOLD_RESET, JITTER_LIMIT_RESET);
      gaps_on = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++)
         send_sample(i * 37 - 700, 700 - i * 53, pick_pressure(i % 2 == 0),
                     1'($urandom_range(0, 1)));

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin thr = 0; jit = 0; end
            1: begin thr = FIELD_MAX; jit = FIELD_MAX; end
            2: begin thr = $urandom_range(1, 200); jit = $urandom_range(1, 15); end
            3: begin thr = $urandom_range(0, FIELD_MAX); jit = $urandom_range(0, FIELD_MAX); end
            4: begin thr = PRESSURE_THRESHOLD_RESET; jit = JITTER_LIMIT_RESET; end
            default: begin thr = $urandom_range(1, 8); jit = $urandom_range(0, 600); end
         endcase
         wait_idle();
         write_regs(thr, jit);
         gaps_on = (ph % 3 != 1);
         if (ph == 2) begin
            run_phase(30);
            wait_idle();
            run_phase(35);
         end else begin
            run_phase(65);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_points.size() != 0);
      repeat (10) @(posedge clock);

      $display("Sent %0d touch samples over %0d register settings, checked %0d points,",
               samples_sent, settings_done, sb.checked);
      $display("including zero and full-scale threshold and jitter limit and a long hold-off.");
      if (sb.errors == 0 && sb.expected_points.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d points missing", sb.errors, sb.expected_points.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
